FILE: src/b64d_pkg.sv
// Shared types and constants for the strict base64 decoder.
// Used by b64d_front, b64d_queue, b64d_back and base64_strict_decoder.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_END_OK    = 2'd1,
    KIND_END_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] PLUS_CODE  = 6'd62;
  localparam logic [5:0] SLASH_CODE = 6'd63;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic             valid;
    logic [5:0]       value;
  } sextet_t;

  // One queue entry: the results caused by one character.
  typedef struct packed {
    logic [1:0]       nbytes;
    logic [2:0][7:0]  bytes;
    logic [2:0][15:0] totals;
    logic             has_end;
    kind_t            end_kind;
    logic [15:0]      end_total;
  } entry_t;

  function automatic sextet_t decode_char(input logic [7:0] ch);
    sextet_t s;
    s.valid = 1'b1;
    s.value = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.value = 6'(ch - 8'h61) + LOWER_BASE;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.value = 6'(ch - 8'h30) + DIGIT_BASE;
    end else if (ch == 8'h2B) begin
      s.value = PLUS_CODE;
    end else if (ch == 8'h2F) begin
      s.value = SLASH_CODE;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/b64d_front.sv
// Front end: classifies each character, tracks group state and counts bytes.
// Builds one b64d_pkg::entry_t per character that causes results.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [7:0]      char_in,
  input  wire logic            is_final,
  input  wire logic            full,
  output logic                 push,
  output b64d_pkg::entry_t     entry
);
  import b64d_pkg::*;

  logic [1:0]             group_position, group_position_next;
  logic [17:0]            held_sextets, held_sextets_next;
  logic                   third_was_pad, third_was_pad_next;
  logic                   error_seen, error_seen_next;
  logic                   padded_group_done, padded_group_done_next;
  logic [COUNT_WIDTH-1:0] byte_counter;
  logic [COUNT_WIDTH-1:0] c1, c2, c3;
  logic [23:0]            w;
  logic [1:0]             nbytes;
  sextet_t                sx;
  logic                   pad;
  logic                   accept;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [15:0] shown(input logic [COUNT_WIDTH-1:0] c);
    return (33'(c) > 33'd65535) ? 16'hFFFF : 16'(c);
  endfunction

  assign accept = in_valid && !full;
  assign sx     = decode_char(char_in);
  assign pad    = (char_in == PAD_CHAR);

  always_comb begin
    group_position_next    = group_position;
    held_sextets_next      = held_sextets;
    third_was_pad_next     = third_was_pad;
    error_seen_next        = error_seen;
    padded_group_done_next = padded_group_done;
    nbytes                 = 2'd0;
    w                      = {held_sextets, 6'b0};
    if (!error_seen) begin
      if (padded_group_done) begin
        error_seen_next = 1'b1;
      end else begin
        case (group_position)
          2'd0: begin
            if (!sx.valid) begin
              error_seen_next = 1'b1;
            end else begin
              held_sextets_next   = {sx.value, held_sextets[11:0]};
              group_position_next = 2'd1;
            end
          end
          2'd1: begin
            if (!sx.valid) begin
              error_seen_next = 1'b1;
            end else begin
              held_sextets_next   = {held_sextets[17:12], sx.value, held_sextets[5:0]};
              group_position_next = 2'd2;
            end
          end
          2'd2: begin
            if (pad) begin
              third_was_pad_next  = 1'b1;
              group_position_next = 2'd3;
            end else if (!sx.valid) begin
              error_seen_next = 1'b1;
            end else begin
              held_sextets_next   = {held_sextets[17:6], sx.value};
              group_position_next = 2'd3;
            end
          end
          default: begin
            if (third_was_pad) begin
              if (!pad) begin
                error_seen_next = 1'b1;
              end else begin
                nbytes                 = 2'd1;
                padded_group_done_next = 1'b1;
              end
            end else if (pad) begin
              nbytes                 = 2'd2;
              padded_group_done_next = 1'b1;
            end else if (!sx.valid) begin
              error_seen_next = 1'b1;
            end else begin
              w      = {held_sextets, sx.value};
              nbytes = 2'd3;
            end
            if (!error_seen_next) begin
              group_position_next = 2'd0;
              held_sextets_next   = '0;
              third_was_pad_next  = 1'b0;
            end
          end
        endcase
      end
    end
  end

  assign c1 = (nbytes >= 2'd1) ? sat_inc(byte_counter) : byte_counter;
  assign c2 = (nbytes >= 2'd2) ? sat_inc(c1) : c1;
  assign c3 = (nbytes == 2'd3) ? sat_inc(c2) : c2;

  always_comb begin
    entry.nbytes    = nbytes;
    entry.bytes[0]  = w[23:16];
    entry.bytes[1]  = w[15:8];
    entry.bytes[2]  = w[7:0];
    entry.totals[0] = shown(c1);
    entry.totals[1] = shown(c2);
    entry.totals[2] = shown(c3);
    entry.has_end   = is_final;
    entry.end_kind  = (error_seen_next || group_position_next != 2'd0) ?
                      KIND_END_ERROR : KIND_END_OK;
    entry.end_total = shown(c3);
  end

  assign push = accept && (nbytes != 2'd0 || is_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position    <= '0;
      held_sextets      <= '0;
      third_was_pad     <= 1'b0;
      error_seen        <= 1'b0;
      padded_group_done <= 1'b0;
      byte_counter      <= '0;
    end else if (accept) begin
      if (is_final) begin
        group_position    <= '0;
        held_sextets      <= '0;
        third_was_pad     <= 1'b0;
        error_seen        <= 1'b0;
        padded_group_done <= 1'b0;
        byte_counter      <= '0;
      end else begin
        group_position    <= group_position_next;
        held_sextets      <= held_sextets_next;
        third_was_pad     <= third_was_pad_next;
        error_seen        <= error_seen_next;
        padded_group_done <= padded_group_done_next;
        byte_counter      <= c3;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/b64d_queue.sv
// Short queue of result entries between front and back end.
// Depends on b64d_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire b64d_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output b64d_pkg::entry_t       head
);
  import b64d_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/b64d_back.sv
// Back end: walks the head entry one result per cycle, unless the output is stalled, into an output register.
// Depends on b64d_pkg for the entry and kind types.
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              empty,
  input  wire b64d_pkg::entry_t  head,
  output logic                   pop,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [1:0]             kind,
  output logic [7:0]             data_byte,
  output logic [15:0]            byte_total,
  output logic                   run_end
);
  import b64d_pkg::*;

  logic [1:0] idx;
  logic [2:0] rcount;
  logic       last;
  logic       load;
  logic       is_data;

  assign rcount  = {1'b0, head.nbytes} + {2'b0, head.has_end};
  assign last    = ({1'b0, idx} + 3'd1 == rcount);
  assign is_data = (idx < head.nbytes);
  assign load    = !empty && (!out_valid || !out_stall);
  assign pop     = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_end <= last;
      if (is_data) begin
        kind       <= KIND_DATA;
        data_byte  <= head.bytes[idx];
        byte_total <= head.totals[idx];
      end else begin
        kind       <= head.end_kind;
        data_byte  <= 8'd0;
        byte_total <= head.end_total;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/base64_strict_decoder.sv
// Top level of the strict base64 decoder: front end, entry queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
// Accepts one character per cycle while the four-entry queue has room or an
// entry leaves it in the same cycle. The front end is combinational: a
// character's results are written into the queue as one entry at the edge
// that accepts it, and the back end later moves them from the queue head
// into its output register. Results then leave one per cycle while the
// output is not stalled, so a full group of four characters yields three
// data bytes and the final character adds one end-status result. Input
// stalls only when the queue is full and no entry leaves in that cycle: the
// back end is still walking the head entry's results or the output stalls.
`timescale 1ns / 1ps
`default_nettype none

module base64_strict_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_in,
  input  wire logic        is_final,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [15:0]      byte_total,
  output logic             run_end
);
  import b64d_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  assign in_stall = full && !pop;

  b64d_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .char_in  (char_in),
    .is_final (is_final),
    .full     (in_stall),
    .push     (push),
    .entry    (push_entry)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .kind       (kind),
    .data_byte  (data_byte),
    .byte_total (byte_total),
    .run_end    (run_end)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> run_end)
    else $error("end status not marked as last result");

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'd0)
    else $error("end status carries a data byte");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("entry pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("entry popped from an empty queue");

endmodule

`default_nettype wire
